// ===== rtl/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg: shared types, constants and microcode for days_between_dates
// Field widths, the control word layout, the microcode table and the
// calendar tables used by the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dbd_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DIST_W  = 22;

	// default upper year limit
	localparam int MAX_YEAR_DEF = 9999;

	// day ordinals up to year 16383 need 23 bits
	localparam int ORD_W = 23;

	// x / 25 == (x * RECIP_25) >> RECIP_SHIFT for any 12-bit x
	localparam int RECIP_25    = 5243;
	localparam int RECIP_SHIFT = 17;
	localparam int QUOT_W      = 8;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// microcode step address
	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_DIVY  = 4'd1;
	localparam step_t STEP_LEAP  = 4'd2;
	localparam step_t STEP_DIVP  = 4'd3;
	localparam step_t STEP_YEARS = 4'd4;
	localparam step_t STEP_CENT  = 4'd5;
	localparam step_t STEP_MONTH = 4'd6;
	localparam step_t STEP_STORE = 4'd7;
	localparam step_t STEP_DIFF  = 4'd8;
	localparam step_t STEP_EMIT  = 4'd9;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIVY,    // quotient of (year >> 2) by 25
		OP_LEAP,    // leap flag of the current year
		OP_DIVP,    // quotient of ((year - 1) >> 2) by 25
		OP_YEARS,   // acc = 365 * (year - 1) + (year - 1) / 4
		OP_CENT,    // acc -= century days, += 400-year days
		OP_MONTH,   // acc += days before month, leap day, day; check date
		OP_STORE,   // keep first ordinal, switch to second date
		OP_DIFF,    // acc = |first - second|
		OP_EMIT     // load the result register
	} op_t;

	// sequencing conditions
	typedef enum logic [1:0] {
		COND_NEXT,      // advance
		COND_WAIT_IN,   // hold until a word is taken
		COND_FIRST,     // jump while on the first date
		COND_WAIT_OUT   // hold until the result register is free, then jump
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		op_t  op;
		logic idle;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic in_fire;
		logic first;
		logic emit_ok;
	} stat_t;

	// microcode table: one date pass is DIVY..STORE, run twice
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE};
		case (s)
			STEP_IDLE:  w = '{op: OP_NOP,   cond: COND_WAIT_IN,  target: STEP_IDLE};
			STEP_DIVY:  w = '{op: OP_DIVY,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_LEAP:  w = '{op: OP_LEAP,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_DIVP:  w = '{op: OP_DIVP,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_YEARS: w = '{op: OP_YEARS, cond: COND_NEXT,     target: STEP_IDLE};
			STEP_CENT:  w = '{op: OP_CENT,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_MONTH: w = '{op: OP_MONTH, cond: COND_NEXT,     target: STEP_IDLE};
			STEP_STORE: w = '{op: OP_STORE, cond: COND_FIRST,    target: STEP_DIVY};
			STEP_DIFF:  w = '{op: OP_DIFF,  cond: COND_NEXT,     target: STEP_IDLE};
			STEP_EMIT:  w = '{op: OP_EMIT,  cond: COND_WAIT_OUT, target: STEP_IDLE};
			default:    w = '{op: OP_NOP,   cond: COND_NEXT,     target: STEP_IDLE};
		endcase
		return w;
	endfunction

	// length of a month, leap aware
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	// days in the year before the first of a month
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/dbd_if.sv =====
// ----------------------------------------------------------------------------
// dbd_if: channel interfaces for days_between_dates
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// date pair channel
interface dbd_in_if;
	import dbd_pkg::*;
	logic               valid;
	logic               ready;
	logic [DAY_W-1:0]   first_day;
	logic [MONTH_W-1:0] first_month;
	logic [YEAR_W-1:0]  first_year;
	logic [DAY_W-1:0]   second_day;
	logic [MONTH_W-1:0] second_month;
	logic [YEAR_W-1:0]  second_year;

	modport source (
		output valid, first_day, first_month, first_year,
		output second_day, second_month, second_year,
		input  ready
	);
	modport sink (
		input  valid, first_day, first_month, first_year,
		input  second_day, second_month, second_year,
		output ready
	);
endinterface

// distance channel
interface dbd_out_if;
	import dbd_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] day_distance;
	logic              bad_date;

	modport source (
		output valid, day_distance, bad_date,
		input  ready
	);
	modport sink (
		input  valid, day_distance, bad_date,
		output ready
	);
endinterface

// ===== rtl/dbd_seq.sv =====
// ----------------------------------------------------------------------------
// dbd_seq: microcode sequencer
// Step counter over the microcode table with conditional jumps; issues one
// datapath operation per step.
// ----------------------------------------------------------------------------
module dbd_seq import dbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t  step_q;
	step_t  step_d;
	ucode_t uw;

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// fetch control word, pick next step
	always_comb begin
		uw = ucode_rom(step_q);
		case (uw.cond)
			COND_NEXT:     step_d = step_t'(step_q + 1'b1);
			COND_WAIT_IN:  step_d = stat.in_fire ? step_t'(step_q + 1'b1) : step_q;
			COND_FIRST:    step_d = stat.first ? uw.target : step_t'(step_q + 1'b1);
			COND_WAIT_OUT: step_d = stat.emit_ok ? uw.target : step_q;
			default:       step_d = STEP_IDLE;
		endcase
		ctrl.op   = uw.op;
		ctrl.idle = (uw.cond == COND_WAIT_IN);
	end

endmodule

// ===== rtl/dbd_dp.sv =====
// ----------------------------------------------------------------------------
// dbd_dp: date datapath
// Input capture, reciprocal divider by 25, ordinal accumulator, date checks
// and the result register.
// ----------------------------------------------------------------------------
module dbd_dp import dbd_pkg::*; #(
	parameter int MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ctrl_t    ctrl,
	output stat_t    stat,
	dbd_in_if.sink   dates,
	dbd_out_if.source result
);

	localparam logic [15:0] MaxYearV = 16'(MAX_YEAR);
	localparam int QuotLo = RECIP_SHIFT;
	localparam int ProdW  = (YEAR_W - 2) + 13;

	// captured word
	logic [DAY_W-1:0]   d1_q, d2_q;
	logic [MONTH_W-1:0] m1_q, m2_q;
	logic [YEAR_W-1:0]  y1_q, y2_q;

	// working registers
	logic               sel_q;
	logic               bad_q;
	logic               leap_q;
	logic [QUOT_W-1:0]  q_q;
	logic [ORD_W-1:0]   acc_q;
	logic [ORD_W-1:0]   ord_a_q;

	// result register
	logic               out_valid_q;
	logic [DIST_W-1:0]  dist_q;
	logic               bad_out_q;

	logic               in_fire;
	logic               emit_ok;
	logic               do_emit;
	logic [DAY_W-1:0]   dy;
	logic [MONTH_W-1:0] mo;
	logic [YEAR_W-1:0]  yr;
	logic [YEAR_W-3:0]  yb;
	logic [YEAR_W-1:0]  prior;
	logic [YEAR_W-3:0]  pb;
	logic [YEAR_W-3:0]  mul_a;
	logic [ProdW-1:0]   prod;
	logic [YEAR_W-3:0]  q25;
	logic               leap_c;
	logic [DAY_W-1:0]   mlen;
	logic               invalid;
	logic [ORD_W-1:0]   years;
	logic [ORD_W-1:0]   cent;
	logic [ORD_W-1:0]   month_sum;
	logic [ORD_W-1:0]   diff;
	logic [DIST_W-1:0]  sat;

	assign in_fire = dates.valid && ctrl.idle;
	assign emit_ok = !out_valid_q || result.ready;
	assign do_emit = (ctrl.op == OP_EMIT) && emit_ok;

	assign dates.ready   = ctrl.idle;
	assign stat.in_fire  = in_fire;
	assign stat.first    = !sel_q;
	assign stat.emit_ok  = emit_ok;

	assign result.valid        = out_valid_q;
	assign result.day_distance = dist_q;
	assign result.bad_date     = bad_out_q;

	// select current date and form the step results
	always_comb begin
		dy    = sel_q ? d2_q : d1_q;
		mo    = sel_q ? m2_q : m1_q;
		yr    = sel_q ? y2_q : y1_q;
		yb    = yr[YEAR_W-1:2];
		prior = yr - 1'b1;
		pb    = prior[YEAR_W-1:2];

		// divide by 25 through the reciprocal
		mul_a = (ctrl.op == OP_DIVP) ? pb : yb;
		prod  = ProdW'(mul_a) * ProdW'(RECIP_25);

		// year divisible by 100 when (year >> 2) == 25 * q and year % 4 == 0
		q25    = (YEAR_W-2)'(q_q) * (YEAR_W-2)'(25);
		leap_c = (yr[1:0] == 2'b00) && ((yb != q25) || (q_q[1:0] == 2'b00));

		mlen    = month_len(mo, leap_q);
		invalid = (mo == '0) || (mo > 4'd12) || (yr == '0) ||
			({2'b00, yr} > MaxYearV) || (dy == '0) || (dy > mlen);

		years     = ORD_W'(prior) * ORD_W'(365) + ORD_W'(pb);
		cent      = acc_q - ORD_W'(q_q) + ORD_W'(q_q[QUOT_W-1:2]);
		month_sum = acc_q + ORD_W'(days_before(mo)) +
			ORD_W'((mo > 4'd2) && leap_q) + ORD_W'(dy);

		diff = (ord_a_q >= acc_q) ? (ord_a_q - acc_q) : (acc_q - ord_a_q);
		// acc holds the distance by the time the result loads
		sat  = (acc_q > ORD_W'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_W-1:0];
	end

	// control state: date select and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				sel_q <= 1'b0;
			end else if (ctrl.op == OP_STORE) begin
				sel_q <= 1'b1;
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: capture, run the step operation, load the result
	always_ff @(posedge clk) begin
		if (in_fire) begin
			d1_q  <= dates.first_day;
			m1_q  <= dates.first_month;
			y1_q  <= dates.first_year;
			d2_q  <= dates.second_day;
			m2_q  <= dates.second_month;
			y2_q  <= dates.second_year;
			bad_q <= 1'b0;
		end
		case (ctrl.op)
			OP_DIVY, OP_DIVP: q_q <= prod[QuotLo +: QUOT_W];
			OP_LEAP:          leap_q <= leap_c;
			OP_YEARS:         acc_q <= years;
			OP_CENT:          acc_q <= cent;
			OP_MONTH: begin
				acc_q <= month_sum;
				bad_q <= bad_q || invalid;
			end
			OP_STORE: begin
				if (!sel_q) begin
					ord_a_q <= acc_q;
				end
			end
			OP_DIFF:          acc_q <= diff;
			OP_EMIT: begin
				if (emit_ok) begin
					dist_q    <= bad_q ? '0 : sat;
					bad_out_q <= bad_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/days_between_dates.sv =====
// ----------------------------------------------------------------------------
// days_between_dates: absolute day distance between two Gregorian dates
// A microcoded sequencer walks each date through a day ordinal and returns
// the distance of the two ordinals, or zero with bad_date on an invalid date.
// ----------------------------------------------------------------------------
//
//  channel  dir  words              handshake
//  -------  ---  -----------------  ---------------
//  dates    in   two dates          valid / ready
//  result   out  distance, flag     valid / ready
//
//  Once a date pair is taken, the microcode runs seven datapath steps per
//  date, then the difference and the result load, and only then returns
//  to idle; a new pair is not taken while a word is being worked on.
//  dates.ready is high only while the sequencer sits on its idle step.
//  A result waiting in the output register does not block a new date pair;
//  the sequencer holds on its last step only until that register frees.
//  Reset (arst_n low) returns the sequencer to idle and drops result.valid.
//
module days_between_dates import dbd_pkg::*; #(
	parameter int MAX_YEAR = MAX_YEAR_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dbd_in_if.sink    dates,
	dbd_out_if.source result
);

	ctrl_t ctrl;
	stat_t stat;

	dbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	dbd_dp #(
		.MAX_YEAR (MAX_YEAR)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.dates  (dates),
		.result (result)
	);

	// one word in flight: no second pair right after a taken one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		dates.valid && dates.ready |=> !dates.ready)
		else $error("date pair accepted twice in a row");

	// a flagged result carries zero distance
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_date |-> result.day_distance == '0)
		else $error("bad date with nonzero distance");

	// a fresh result never comes straight out of an idle cycle
	a_no_idle_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> !$past(dates.ready))
		else $error("result raised while sequencer idle");

endmodule
